FILE: hw/rtl/itp_pkg.sv
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 36;
    localparam int ECNT_W          = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_FN_C   = 8'h63;
    localparam logic [7:0] CH_FN_E   = 8'h65;
    localparam logic [7:0] CH_FN_L   = 8'h6C;
    localparam logic [7:0] CH_FN_S   = 8'h73;
    localparam logic [7:0] CH_FN_T   = 8'h74;

    typedef logic [4:0] t_addr;

    localparam t_addr S_IDLE   = 5'd0;
    localparam t_addr S_DISP   = 5'd1;
    localparam t_addr S_PH1    = 5'd2;
    localparam t_addr S_PH2A   = 5'd3;
    localparam t_addr S_PH2B   = 5'd4;
    localparam t_addr S_PH2C   = 5'd5;
    localparam t_addr S_PH2D   = 5'd6;
    localparam t_addr S_PH3    = 5'd7;
    localparam t_addr S_NEGA   = 5'd8;
    localparam t_addr S_NEGB   = 5'd9;
    localparam t_addr S_OPR    = 5'd10;
    localparam t_addr S_OPR_P  = 5'd11;
    localparam t_addr S_OPR_S  = 5'd12;
    localparam t_addr S_PUSH   = 5'd13;
    localparam t_addr S_RP     = 5'd14;
    localparam t_addr S_RP_T   = 5'd15;
    localparam t_addr S_RP_P   = 5'd16;
    localparam t_addr S_RP_S   = 5'd17;
    localparam t_addr S_RP_LP  = 5'd18;
    localparam t_addr S_RP_F   = 5'd19;
    localparam t_addr S_RP_FP  = 5'd20;
    localparam t_addr S_RP_FS  = 5'd21;
    localparam t_addr S_OPND   = 5'd22;
    localparam t_addr S_OPND_S = 5'd23;
    localparam t_addr S_FLUSH  = 5'd24;
    localparam t_addr S_FL_T   = 5'd25;
    localparam t_addr S_FL_P   = 5'd26;
    localparam t_addr S_FL_S   = 5'd27;
    localparam t_addr S_FIN    = 5'd28;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SKIP    = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;
    localparam logic [1:0] PH_CLOSER  = 2'd3;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_CH,
        EM_SPACE,
        EM_TOP,
        EM_ZERO,
        EM_MINUS
    } t_emit_sel;

    typedef enum logic [1:0] {
        SO_NONE,
        SO_PUSH,
        SO_POP
    } t_stk_op;

    typedef enum logic [1:0] {
        JM_NEXT,
        JM_COND,
        JM_ALWAYS,
        JM_DISPATCH
    } t_jmp;

    typedef enum logic [2:0] {
        C_NO_ACC,
        C_NO_PREC_POP,
        C_EMPTY,
        C_TOP_LP,
        C_NOT_TOPFUNC,
        C_NOT_LA_SEP,
        C_NOT_LAST
    } t_cond;

    typedef struct packed {
        t_emit_sel  emit;
        t_stk_op    stk;
        t_jmp       jmp;
        t_cond      cond;
        t_addr      target;
        logic       phase_wr;
        logic [1:0] phase_val;
        logic       chk_close;
        logic       finish;
        logic       ready;
    } t_uword;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] wdata;
    } t_stk_ctl;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic       paren_zero;
        logic [7:0] top;
    } t_stk_stat;

    typedef struct packed {
        logic       emit;
        logic       finish;
        logic [7:0] ch;
    } t_out_ctl;

    typedef struct packed {
        logic pend_valid;
        logic busy;
    } t_out_stat;

    function automatic logic is_func(input logic [7:0] c);
        return (c == CH_FN_S) || (c == CH_FN_C) || (c == CH_FN_T) ||
               (c == CH_FN_E) || (c == CH_FN_L);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_CARET) || is_func(c);
    endfunction

    function automatic logic [2:0] prec(input logic [7:0] c);
        logic [2:0] p;
        p = 3'd0;
        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            p = 3'd1;
        end else if ((c == CH_STAR) || (c == CH_SLASH)) begin
            p = 3'd2;
        end else if (c == CH_CARET) begin
            p = 3'd3;
        end else if (is_func(c)) begin
            p = 3'd4;
        end
        return p;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_CARET) || (c == CH_LPAREN) ||
               (c == CH_RPAREN) || (c == CH_NUL);
    endfunction

endpackage

FILE: hw/rtl/itp_rom.sv
module itp_rom (
    input  itp_pkg::t_addr  i_pc,
    output itp_pkg::t_uword o_word
);
    import itp_pkg::*;

    always_comb begin
        o_word = '{emit: EM_NONE, stk: SO_NONE, jmp: JM_NEXT, cond: C_NO_ACC,
                   target: S_IDLE, phase_wr: 1'b0, phase_val: PH_IDLE,
                   chk_close: 1'b0, finish: 1'b0, ready: 1'b0};
        unique case (i_pc)
            S_IDLE: begin
                o_word.ready  = 1'b1;
                o_word.jmp    = JM_COND;
                o_word.cond   = C_NO_ACC;
                o_word.target = S_IDLE;
            end
            S_DISP: begin
                o_word.chk_close = 1'b1;
                o_word.jmp       = JM_DISPATCH;
            end
            S_PH1: begin
                o_word.phase_wr  = 1'b1;
                o_word.phase_val = PH_LITERAL;
                o_word.jmp       = JM_ALWAYS;
                o_word.target    = S_FLUSH;
            end
            S_PH2A: begin
                o_word.emit      = EM_CH;
                o_word.phase_wr  = 1'b1;
                o_word.phase_val = PH_CLOSER;
            end
            S_PH2B: begin
                o_word.emit = EM_SPACE;
            end
            S_PH2C: begin
                o_word.emit = EM_MINUS;
            end
            S_PH2D: begin
                o_word.emit   = EM_SPACE;
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_FLUSH;
            end
            S_PH3: begin
                o_word.phase_wr  = 1'b1;
                o_word.phase_val = PH_IDLE;
                o_word.jmp       = JM_ALWAYS;
                o_word.target    = S_FLUSH;
            end
            S_NEGA: begin
                o_word.emit      = EM_ZERO;
                o_word.phase_wr  = 1'b1;
                o_word.phase_val = PH_SKIP;
            end
            S_NEGB: begin
                o_word.emit   = EM_SPACE;
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_FLUSH;
            end
            S_OPR: begin
                o_word.jmp    = JM_COND;
                o_word.cond   = C_NO_PREC_POP;
                o_word.target = S_PUSH;
            end
            S_OPR_P: begin
                o_word.emit = EM_TOP;
                o_word.stk  = SO_POP;
            end
            S_OPR_S: begin
                o_word.emit   = EM_SPACE;
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_OPR;
            end
            S_PUSH: begin
                o_word.stk    = SO_PUSH;
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_FLUSH;
            end
            S_RP: begin
                o_word.jmp    = JM_COND;
                o_word.cond   = C_EMPTY;
                o_word.target = S_FLUSH;
            end
            S_RP_T: begin
                o_word.jmp    = JM_COND;
                o_word.cond   = C_TOP_LP;
                o_word.target = S_RP_LP;
            end
            S_RP_P: begin
                o_word.emit = EM_TOP;
                o_word.stk  = SO_POP;
            end
            S_RP_S: begin
                o_word.emit   = EM_SPACE;
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_RP;
            end
            S_RP_LP: begin
                o_word.stk = SO_POP;
            end
            S_RP_F: begin
                o_word.jmp    = JM_COND;
                o_word.cond   = C_NOT_TOPFUNC;
                o_word.target = S_FLUSH;
            end
            S_RP_FP: begin
                o_word.emit = EM_TOP;
                o_word.stk  = SO_POP;
            end
            S_RP_FS: begin
                o_word.emit   = EM_SPACE;
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_FLUSH;
            end
            S_OPND: begin
                o_word.emit   = EM_CH;
                o_word.jmp    = JM_COND;
                o_word.cond   = C_NOT_LA_SEP;
                o_word.target = S_FLUSH;
            end
            S_OPND_S: begin
                o_word.emit = EM_SPACE;
            end
            S_FLUSH: begin
                o_word.jmp    = JM_COND;
                o_word.cond   = C_NOT_LAST;
                o_word.target = S_FIN;
            end
            S_FL_T: begin
                o_word.jmp    = JM_COND;
                o_word.cond   = C_EMPTY;
                o_word.target = S_FIN;
            end
            S_FL_P: begin
                o_word.emit = EM_TOP;
                o_word.stk  = SO_POP;
            end
            S_FL_S: begin
                o_word.emit   = EM_SPACE;
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_FL_T;
            end
            S_FIN: begin
                o_word.finish = 1'b1;
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_IDLE;
            end
            default: begin
                o_word.jmp    = JM_ALWAYS;
                o_word.target = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/itp_stack.sv
module itp_stack #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itp_pkg::t_stk_ctl   i_ctl,
    output itp_pkg::t_stk_stat  o_stat
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic [7:0]    mem [STACK_DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_lp_cnt;
    logic [CW-1:0] n_lp_cnt;
    logic [7:0]    r_top;
    logic [AW-1:0] rd_addr;
    logic          push_ok;
    logic          pop_ok;

    always_comb begin
        push_ok  = i_ctl.push && (r_count != FULL);
        pop_ok   = i_ctl.pop && (r_count != '0);
        n_count  = r_count;
        n_lp_cnt = r_lp_cnt;
        if (i_ctl.clear) begin
            n_count  = '0;
            n_lp_cnt = '0;
        end else if (push_ok) begin
            n_count = r_count + CW'(1);
            if (i_ctl.wdata == CH_LPAREN) begin
                n_lp_cnt = r_lp_cnt + CW'(1);
            end
        end else if (pop_ok) begin
            n_count = r_count - CW'(1);
            if (r_top == CH_LPAREN) begin
                n_lp_cnt = r_lp_cnt - CW'(1);
            end
        end
        rd_addr = (n_count == '0) ? '0 : AW'(n_count - CW'(1));
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count == FULL);
        o_stat.paren_zero = (r_lp_cnt == '0);
        o_stat.top        = r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_lp_cnt <= '0;
        end else begin
            r_count  <= n_count;
            r_lp_cnt <= n_lp_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok && !i_ctl.clear) begin
            mem[r_count[AW-1:0]] <= i_ctl.wdata;
        end
        if (push_ok && !i_ctl.clear) begin
            r_top <= i_ctl.wdata;
        end else begin
            r_top <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("Stack count exceeds the stack depth.");
    a_lp_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lp_cnt <= r_count)
        else $error("Open parenthesis count exceeds the stack count.");
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push && (r_count == FULL) && !i_ctl.clear |=> r_count == $past(r_count))
        else $error("A push onto a full stack changed the count.");
`endif

endmodule

FILE: hw/rtl/itp_out.sv
module itp_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itp_pkg::t_out_ctl  i_ctl,
    input  logic               i_err,
    input  logic               i_out_ready,
    output itp_pkg::t_out_stat o_stat,
    output logic               o_out_valid,
    output logic [7:0]         o_char_out,
    output logic               o_last_of_run,
    output logic               o_error_flag
);
    import itp_pkg::*;

    logic       r_pend_valid;
    logic [7:0] r_pend_char;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;
    logic       r_out_err;
    logic       move;

    always_comb begin
        move              = (i_ctl.emit || i_ctl.finish) && r_pend_valid;
        o_stat.pend_valid = r_pend_valid;
        o_stat.busy       = r_out_valid && !i_out_ready;
        o_out_valid       = r_out_valid;
        o_char_out        = r_out_char;
        o_last_of_run     = r_out_last;
        o_error_flag      = r_out_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_ctl.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_pend_char <= i_ctl.ch;
        end
        if (move) begin
            r_out_char <= r_pend_char;
            r_out_last <= i_ctl.finish;
            r_out_err  <= i_err;
        end
    end

endmodule

FILE: hw/rtl/infix_to_postfix_converter.sv
// Streaming infix-to-postfix converter with a bounded operator stack.
// The input channel (i_in_valid, o_in_ready) takes one infix character per
// transaction, with the character after it and a flag on the final one.
// The output channel (o_out_valid, i_out_ready) returns postfix characters,
// a space after each token, with a flag on the last character caused by an
// input transaction and the sticky error of the current expression.
// A microprogram runs each item at one control word per cycle while the
// output does not stall, and one item is taken at a time.
// A finished character waits in a pending register and then in the output
// register, so the converter keeps working while the receiver stalls until
// both are full, and then holds its step.
// Reset empties the stack, clears the error and the negative-literal phase,
// and drops any character not yet delivered.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic [7:0] i_lookahead_char,
    input  logic       i_end_of_expr,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_char_out,
    output logic       o_last_of_run,
    output logic       o_error_flag
);
    import itp_pkg::*;

    t_addr                r_pc;
    t_addr                n_pc;
    t_uword               word;
    logic [7:0]           r_ch;
    logic [7:0]           r_la;
    logic                 r_last;
    logic [1:0]           r_phase;
    logic [1:0]           n_phase;
    logic                 r_err;
    logic                 n_err;
    logic [ECNT_W-1:0]    r_ecnt;
    logic [ECNT_W-1:0]    n_ecnt;
    t_stk_ctl             stk_ctl;
    t_stk_stat            stk_stat;
    t_out_ctl             out_ctl;
    t_out_stat            out_stat;
    logic                 accept;
    logic                 cond_true;
    logic                 eff_emit;
    logic                 stall;
    t_addr                disp_tgt;

    itp_rom u_rom (
        .i_pc   (r_pc),
        .o_word (word)
    );

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_stat  (stk_stat)
    );

    itp_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (out_ctl),
        .i_err         (r_err),
        .i_out_ready   (i_out_ready),
        .o_stat        (out_stat),
        .o_out_valid   (o_out_valid),
        .o_char_out    (o_char_out),
        .o_last_of_run (o_last_of_run),
        .o_error_flag  (o_error_flag)
    );

    always_comb begin
        o_in_ready = word.ready;
        accept     = i_in_valid && word.ready;

        case (word.cond)
            C_NO_ACC:      cond_true = !accept;
            C_NO_PREC_POP: cond_true = stk_stat.empty || (prec(r_ch) > prec(stk_stat.top));
            C_EMPTY:       cond_true = stk_stat.empty;
            C_TOP_LP:      cond_true = (stk_stat.top == CH_LPAREN);
            C_NOT_TOPFUNC: cond_true = stk_stat.empty || !is_func(stk_stat.top);
            C_NOT_LA_SEP:  cond_true = !is_sep(r_la);
            C_NOT_LAST:    cond_true = !r_last;
            default:       cond_true = 1'b0;
        endcase

        if (r_phase == PH_SKIP) begin
            disp_tgt = S_PH1;
        end else if (r_phase == PH_LITERAL) begin
            disp_tgt = S_PH2A;
        end else if (r_phase == PH_CLOSER) begin
            disp_tgt = S_PH3;
        end else if (is_oper(r_ch)) begin
            disp_tgt = S_OPR;
        end else if ((r_ch == CH_LPAREN) && (r_la == CH_MINUS)) begin
            disp_tgt = S_NEGA;
        end else if (r_ch == CH_LPAREN) begin
            disp_tgt = S_PUSH;
        end else if (r_ch == CH_RPAREN) begin
            disp_tgt = S_RP;
        end else begin
            disp_tgt = S_OPND;
        end

        eff_emit = (word.emit != EM_NONE) && (r_ecnt < ECNT_W'(MAX_RESULTS));
        stall    = (eff_emit || word.finish) && out_stat.pend_valid && out_stat.busy;

        unique case (word.jmp)
            JM_NEXT:     n_pc = r_pc + t_addr'(1);
            JM_COND:     n_pc = cond_true ? word.target : r_pc + t_addr'(1);
            JM_ALWAYS:   n_pc = word.target;
            JM_DISPATCH: n_pc = disp_tgt;
            default:     n_pc = S_IDLE;
        endcase
        if (stall) begin
            n_pc = r_pc;
        end

        case (word.emit)
            EM_CH:    out_ctl.ch = r_ch;
            EM_SPACE: out_ctl.ch = CH_SPACE;
            EM_TOP:   out_ctl.ch = stk_stat.top;
            EM_ZERO:  out_ctl.ch = CH_ZERO;
            EM_MINUS: out_ctl.ch = CH_MINUS;
            default:  out_ctl.ch = CH_SPACE;
        endcase
        out_ctl.emit   = eff_emit && !stall;
        out_ctl.finish = word.finish && !stall;

        stk_ctl.push  = (word.stk == SO_PUSH) && !stall;
        stk_ctl.pop   = (word.stk == SO_POP) && !stall;
        stk_ctl.clear = word.finish && r_last && !stall;
        stk_ctl.wdata = r_ch;

        n_err = r_err;
        if (word.chk_close && (r_phase == PH_IDLE) && (r_ch == CH_RPAREN) &&
            stk_stat.paren_zero) begin
            n_err = 1'b1;
        end
        if (stk_ctl.push && stk_stat.full) begin
            n_err = 1'b1;
        end
        if (stk_ctl.clear) begin
            n_err = 1'b0;
        end

        n_phase = r_phase;
        if (word.phase_wr && !stall) begin
            n_phase = word.phase_val;
        end
        if (stk_ctl.clear) begin
            n_phase = PH_IDLE;
        end

        n_ecnt = r_ecnt;
        if (accept) begin
            n_ecnt = '0;
        end else if (out_ctl.emit) begin
            n_ecnt = r_ecnt + ECNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= S_IDLE;
            r_phase <= PH_IDLE;
            r_err   <= 1'b0;
            r_ecnt  <= '0;
        end else begin
            r_pc    <= n_pc;
            r_phase <= n_phase;
            r_err   <= n_err;
            r_ecnt  <= n_ecnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch   <= i_char_in;
            r_la   <= i_lookahead_char;
            r_last <= i_end_of_expr;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_FIN) && r_last && !stall
        |=> stk_stat.empty && (r_phase == PH_IDLE) && !r_err)
        else $error("State not cleared after the final character.");
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_IDLE) |-> !out_stat.pend_valid)
        else $error("A pending character outlived its input transaction.");
    a_ecnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= ECNT_W'(MAX_RESULTS))
        else $error("Result count exceeds the per-item limit.");
`endif

endmodule
